>>> hdl/vrms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrms_pkg
// Shared types and constants for the voxel ray march block.
// ----------------------------------------------------------------------------
package vrms_pkg;

  // grid store edge; the voxel ports carry 5 bits per axis
  localparam int GRID_MAX_DIM = 32;

  localparam logic [1:0] REG_GRID_X = 2'd0;
  localparam logic [1:0] REG_GRID_Y = 2'd1;
  localparam logic [1:0] REG_GRID_Z = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [10:0] HALF_STEP = 11'd1024;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture query, clear radius and previous value
    logic sqrt_step; // one iteration of the max radius root
    logic rd_march;  // issue read at radius r
    logic rd_mid;    // issue read at bisection midpoint
    logic eval;      // consume read data of a march step
    logic bis_init;  // set lo/hi around r
    logic bis_upd;   // consume read data of a bisection step
    logic done_hit;  // latch hi as result
    logic done_miss; // latch maxr as result
  } ctl_cmd_t;

  typedef struct packed {
    logic rise;      // current read is a rise
    logic past_max;  // next radius beyond maxr
    logic sqrt_done;
  } dp_stat_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SQRT  = 8'b0000_0010,
    ST_MRD   = 8'b0000_0100,
    ST_MADR  = 8'b0000_1000,
    ST_MEV   = 8'b0001_0000,
    ST_BRD   = 8'b0010_0000,
    ST_BADR  = 8'b0100_0000,
    ST_BEV   = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

>>> hdl/vrms_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrms_ram
// Generic single-port ram with registered read.
// ----------------------------------------------------------------------------
module vrms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

>>> hdl/vrms_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrms_ctrl
// Sequencer for the march and bisection loops.
// ----------------------------------------------------------------------------
module vrms_ctrl #(
  parameter int BISECT_STEPS    = 10,
  parameter int MAX_MARCH_STEPS = 8192
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire vrms_pkg::dp_stat_t stat,
  output vrms_pkg::ctl_cmd_t      cmd,
  output logic                    busy
);

  localparam int SW = $clog2(MAX_MARCH_STEPS + 1);
  localparam int BW = $clog2(BISECT_STEPS + 1);

  vrms_pkg::state_t state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [BW-1:0] bis_r, bis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vrms_pkg::ST_IDLE;
      step_r  <= '0;
      bis_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      bis_r   <= bis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    bis_nxt   = bis_r;
    cmd       = '0;
    unique case (state_r)
      vrms_pkg::ST_IDLE: begin
        if (go) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = vrms_pkg::ST_SQRT;
        end
      end
      vrms_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_done) state_nxt = vrms_pkg::ST_MRD;
      end
      vrms_pkg::ST_MRD: begin
        cmd.rd_march = 1'b1;
        state_nxt    = vrms_pkg::ST_MADR;
      end
      vrms_pkg::ST_MADR: begin
        state_nxt = vrms_pkg::ST_MEV;
      end
      vrms_pkg::ST_MEV: begin
        if (stat.rise) begin
          cmd.bis_init = 1'b1;
          bis_nxt      = '0;
          state_nxt    = vrms_pkg::ST_BRD;
        end else if (stat.past_max || step_r == SW'(MAX_MARCH_STEPS - 1)) begin
          cmd.done_miss = 1'b1;
          state_nxt     = vrms_pkg::ST_IDLE;
        end else begin
          cmd.eval  = 1'b1;
          step_nxt  = step_r + 1'b1;
          state_nxt = vrms_pkg::ST_MRD;
        end
      end
      vrms_pkg::ST_BRD: begin
        if (bis_r == BW'(BISECT_STEPS)) begin
          cmd.done_hit = 1'b1;
          state_nxt    = vrms_pkg::ST_IDLE;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt  = vrms_pkg::ST_BADR;
        end
      end
      vrms_pkg::ST_BADR: begin
        state_nxt = vrms_pkg::ST_BEV;
      end
      vrms_pkg::ST_BEV: begin
        cmd.bis_upd = 1'b1;
        bis_nxt     = bis_r + 1'b1;
        state_nxt   = vrms_pkg::ST_BRD;
      end
      default: state_nxt = vrms_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state_r != vrms_pkg::ST_IDLE);

endmodule
`default_nettype wire

>>> hdl/vrms_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrms_dp
// Datapath: radius, max radius root, address generation and grid store.
// ----------------------------------------------------------------------------
module vrms_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire vrms_pkg::ctl_cmd_t cmd,
  output vrms_pkg::dp_stat_t      stat,
  // voxel write
  input  wire logic               wr_en,
  input  wire logic [4:0]         wr_x,
  input  wire logic [4:0]         wr_y,
  input  wire logic [4:0]         wr_z,
  input  wire logic [7:0]         wr_val,
  // query
  input  wire logic signed [15:0] q_dx,
  input  wire logic signed [15:0] q_dy,
  input  wire logic signed [15:0] q_dz,
  input  wire logic [5:0]         gsx,
  input  wire logic [5:0]         gsy,
  input  wire logic [5:0]         gsz,
  input  wire logic [7:0]         thr,
  output logic [15:0]             res_radius,
  output logic                    res_hit,
  output logic                    res_valid
);

  localparam int AW = $clog2(vrms_pkg::GRID_MAX_DIM);
  localparam int DEPTH = vrms_pkg::GRID_MAX_DIM * vrms_pkg::GRID_MAX_DIM *
                         vrms_pkg::GRID_MAX_DIM;
  localparam int MW = 3 * AW;
  localparam int GW = AW + 1;
  // squared sum times 2^20 fits in this many bits
  localparam int NW = 2 * AW + 2 + 20;
  localparam int RW = NW / 2 + 1;

  logic signed [15:0] dx_r, dy_r, dz_r;
  logic [GW-1:0] gx_r, gy_r, gz_r;
  logic [7:0] thr_r;
  logic [RW-1:0] r_r, lo_r, hi_r, maxr_r, rd_rad_r;
  logic [7:0] last_r;
  logic [NW-1:0] sq_n_r, sq_res_r, sq_bit_r;
  logic [RW-1:0] radius;
  logic oob_r;

  function automatic logic [GW-1:0] eff(input logic [5:0] g);
    logic [GW-1:0] e;
    if (g == 6'd0) e = GW'(1);
    else if (32'(g) > vrms_pkg::GRID_MAX_DIM) e = GW'(vrms_pkg::GRID_MAX_DIM);
    else e = GW'(g);
    return e;
  endfunction

  // per-axis voxel index, feeds the ram address directly
  logic [AW-1:0] ax, ay, az;
  logic ox, oy, oz;

  function automatic logic [AW:0] axis(input logic [GW-1:0] g,
                                       input logic signed [15:0] d,
                                       input logic [RW-1:0] r);
    logic signed [RW+18:0] p;
    logic signed [RW+18:0] t;
    logic [RW+18:0] v;
    logic bad;
    p = (RW+19)'(d) * (RW+19)'($signed({1'b0, r}));
    // center (g-1)/2 plus the rounding half voxel is g/2
    t = p + $signed((RW+19)'(g) << 24);
    v = t >>> 25;
    bad = t[RW+18] || (v >= (RW+19)'(g));
    return {bad, v[AW-1:0]};
  endfunction

  logic [AW:0] rx, ry, rz;
  always_comb begin
    radius = cmd.rd_mid ? RW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1) : r_r;
    rx = axis(gx_r, dx_r, rd_rad_r);
    ry = axis(gy_r, dy_r, rd_rad_r);
    rz = axis(gz_r, dz_r, rd_rad_r);
    {ox, ax} = rx;
    {oy, ay} = ry;
    {oz, az} = rz;
  end

  // read radius latched, then address computed and ram read in the next cycle
  logic [MW-1:0] ram_addr;
  logic [7:0] ram_q;
  logic [7:0] occ;

  always_ff @(posedge clk) begin
    if (cmd.rd_march || cmd.rd_mid) rd_rad_r <= radius;
    oob_r <= ox | oy | oz;
  end

  assign ram_addr = wr_en ? {wr_z[AW-1:0], wr_y[AW-1:0], wr_x[AW-1:0]} : {az, ay, ax};

  vrms_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .addr (ram_addr),
    .wdata(wr_val),
    .rdata(ram_q)
  );

  assign occ = oob_r ? 8'd0 : ram_q;

  // restoring square root, one result bit per cycle
  logic [NW-1:0] sq_sum;
  logic [NW-1:0] ex, ey, ez;
  always_comb begin
    ex = NW'(eff(gsx) - 1'b1);
    ey = NW'(eff(gsy) - 1'b1);
    ez = NW'(eff(gsz) - 1'b1);
    sq_sum = (ex * ex + ey * ey + ez * ez) << 20;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= cmd.done_hit | cmd.done_miss;
    end
    if (cmd.load) begin
      dx_r <= q_dx;
      dy_r <= q_dy;
      dz_r <= q_dz;
      gx_r <= eff(gsx);
      gy_r <= eff(gsy);
      gz_r <= eff(gsz);
      thr_r <= thr;
      r_r <= '0;
      last_r <= '0;
      sq_n_r <= sq_sum;
      sq_res_r <= '0;
      sq_bit_r <= NW'(1) << (2 * ((NW - 1) / 2));
    end
    if (cmd.sqrt_step && sq_bit_r != '0) begin
      if (sq_n_r >= sq_res_r + sq_bit_r) begin
        sq_n_r <= sq_n_r - (sq_res_r + sq_bit_r);
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
    if (cmd.sqrt_step) maxr_r <= RW'(sq_res_r);
    if (cmd.eval) begin
      last_r <= occ;
      r_r <= r_r + RW'(vrms_pkg::HALF_STEP);
    end
    if (cmd.bis_init) begin
      lo_r <= (r_r >= RW'(vrms_pkg::HALF_STEP)) ? r_r - RW'(vrms_pkg::HALF_STEP) : '0;
      hi_r <= r_r;
    end
    if (cmd.bis_upd) begin
      if (occ >= thr_r) hi_r <= rd_rad_r;
      else lo_r <= rd_rad_r;
    end
    if (cmd.done_hit) begin
      res_hit <= 1'b1;
      res_radius <= (hi_r > RW'(16'hFFFF)) ? 16'hFFFF : hi_r[15:0];
    end
    if (cmd.done_miss) begin
      res_hit <= 1'b0;
      res_radius <= (maxr_r > RW'(16'hFFFF)) ? 16'hFFFF : maxr_r[15:0];
    end
  end

  assign stat.rise      = (occ >= thr_r) && (last_r < thr_r);
  assign stat.past_max  = (r_r + RW'(vrms_pkg::HALF_STEP)) > maxr_r;
  assign stat.sqrt_done = (sq_bit_r == '0);

endmodule
`default_nettype wire

>>> hdl/voxel_ray_march_surface_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_ray_march_surface_top
// Voxel grid ray march with bisection refinement of the surface radius.
// ----------------------------------------------------------------------------
// a voxel write takes only its accept cycle; busy stays low
// a query holds busy through the max radius root, each march step and each
// bisection step: up to 54 march steps and 10 bisections
// the result word shows for one cycle on out_valid as busy drops; no stall
// synchronous reset sets the grid size to 32 and the threshold to 128;
// the grid ram holds no reset value
module voxel_ray_march_surface_top #(
  parameter int BISECT_STEPS    = 10,
  parameter int MAX_MARCH_STEPS = 8192
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_req_type,
  input  wire logic [4:0]         in_voxel_x,
  input  wire logic [4:0]         in_voxel_y,
  input  wire logic [4:0]         in_voxel_z,
  input  wire logic [7:0]         in_occupancy_value,
  input  wire logic signed [15:0] in_dir_x,
  input  wire logic signed [15:0] in_dir_y,
  input  wire logic signed [15:0] in_dir_z,
  output logic                    out_valid,
  output logic [15:0]             out_surface_radius,
  output logic                    out_surface_hit,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data
);

  logic [5:0] gsx_r, gsy_r, gsz_r;
  logic [7:0] thr_r;
  logic accept, wr_en, go;
  vrms_pkg::ctl_cmd_t cmd;
  vrms_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;
  assign accept = start && !busy;
  assign go     = accept && in_req_type == vrms_pkg::REQ_QUERY;
  assign wr_en  = accept && in_req_type == vrms_pkg::REQ_WRITE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gsx_r <= 6'd32;
      gsy_r <= 6'd32;
      gsz_r <= 6'd32;
      thr_r <= 8'd128;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vrms_pkg::REG_GRID_X: gsx_r <= cfg_data[5:0];
        vrms_pkg::REG_GRID_Y: gsy_r <= cfg_data[5:0];
        vrms_pkg::REG_GRID_Z: gsz_r <= cfg_data[5:0];
        vrms_pkg::REG_THRESH: thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  vrms_ctrl #(.BISECT_STEPS(BISECT_STEPS), .MAX_MARCH_STEPS(MAX_MARCH_STEPS)) u_ctrl (
    .clk (clk),
    .rst_n(rst_n),
    .go  (go),
    .stat(stat),
    .cmd (cmd),
    .busy(busy)
  );

  vrms_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .wr_en     (wr_en),
    .wr_x      (in_voxel_x),
    .wr_y      (in_voxel_y),
    .wr_z      (in_voxel_z),
    .wr_val    (in_occupancy_value),
    .q_dx      (in_dir_x),
    .q_dy      (in_dir_y),
    .q_dz      (in_dir_z),
    .gsx       (gsx_r),
    .gsy       (gsy_r),
    .gsz       (gsz_r),
    .thr       (thr_r),
    .res_radius(out_surface_radius),
    .res_hit   (out_surface_hit),
    .res_valid (out_valid)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> busy) else $error("query not taken");
  a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.done_hit && cmd.done_miss)) else $error("two results at once");
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without query");

endmodule
`default_nettype wire

>>> dv/tb_voxel_ray_march_surface_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_voxel_ray_march_surface_top
// Fills the occupancy grid in phases of different grid sizes and thresholds,
// fires ray queries in every direction range and checks each returned radius
// and hit flag against a cycle-free march-and-bisect predictor.
// ----------------------------------------------------------------------------
module tb_voxel_ray_march_surface_top;

  localparam int DIM       = 32;
  localparam int BISECT    = 10;
  localparam int MAX_STEPS = 8192;
  localparam int WDOG_MAX  = 20000;
  localparam int N_ITEMS   = 1650;

  typedef struct {
    logic               req;
    logic [4:0]         vx, vy, vz;
    logic [7:0]         occ;
    logic signed [15:0] dx, dy, dz;
  } voxel_req_t;

  typedef struct {
    logic [15:0] radius;
    logic        hit;
  } surface_t;

  logic clk, rst_n, start, busy;
  logic in_req_type;
  logic [4:0] in_voxel_x, in_voxel_y, in_voxel_z;
  logic [7:0] in_occupancy_value;
  logic signed [15:0] in_dir_x, in_dir_y, in_dir_z;
  logic out_valid, out_surface_hit;
  logic [15:0] out_surface_radius;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  voxel_ray_march_surface_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_voxel_x(in_voxel_x), .in_voxel_y(in_voxel_y),
    .in_voxel_z(in_voxel_z), .in_occupancy_value(in_occupancy_value),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .out_valid(out_valid), .out_surface_radius(out_surface_radius),
    .out_surface_hit(out_surface_hit),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic [7:0] grid_occ [DIM*DIM*DIM];
  logic [5:0] size_x = 6'd32, size_y = 6'd32, size_z = 6'd32;
  logic [7:0] solid_thr = 8'd128;

  voxel_req_t pending_words[$];
  surface_t   expected_surf[$];
  voxel_req_t cur;
  int         gap_cnt;
  bit         quiet;
  int         err_cnt;
  int         wdog;

  function automatic void add_word(voxel_req_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic int eff_dim(logic [5:0] g);
    if (g == 0) return 1;
    if (g > DIM) return DIM;
    return g;
  endfunction

  // voxel index along one axis, -1 when outside the grid
  function automatic int axis_index(int g, logic signed [15:0] d, longint r);
    longint t;
    t = (longint'(g - 1) <<< 24) + longint'(d) * r + (longint'(1) <<< 24);
    if (t < 0) return -1;
    t = t >>> 25;
    if (t >= g) return -1;
    return int'(t);
  endfunction

  function automatic int occ_at(int gx, int gy, int gz, voxel_req_t q, longint r);
    int x, y, z;
    x = axis_index(gx, q.dx, r);
    y = axis_index(gy, q.dy, r);
    z = axis_index(gz, q.dz, r);
    if (x < 0 || y < 0 || z < 0) return 0;
    return grid_occ[(z * DIM + y) * DIM + x];
  endfunction

  function automatic longint int_root(longint n);
    longint lo, hi, mid;
    lo = 0;
    hi = 65536;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic surface_t march_predict(voxel_req_t q);
    int gx, gy, gz, o, prev_occ;
    longint maxr, r, lo, hi, mid, res;
    surface_t s;
    gx = eff_dim(size_x);
    gy = eff_dim(size_y);
    gz = eff_dim(size_z);
    maxr = int_root(longint'((gx-1)*(gx-1) + (gy-1)*(gy-1) + (gz-1)*(gz-1)) <<< 20);
    res = maxr;
    s.hit = 1'b0;
    r = 0;
    prev_occ = 0;
    for (int i = 0; i < MAX_STEPS; i++) begin
      o = occ_at(gx, gy, gz, q, r);
      if (o >= solid_thr && prev_occ < solid_thr) begin
        lo = (r >= vrms_pkg::HALF_STEP) ? r - vrms_pkg::HALF_STEP : 0;
        hi = r;
        for (int k = 0; k < BISECT; k++) begin
          mid = (lo + hi) >>> 1;
          if (occ_at(gx, gy, gz, q, mid) >= solid_thr) hi = mid;
          else lo = mid;
        end
        res = hi;
        s.hit = 1'b1;
        break;
      end
      prev_occ = o;
      r = r + vrms_pkg::HALF_STEP;
      if (r > maxr) break;
    end
    s.radius = (res > 65535) ? 16'hFFFF : res[15:0];
    return s;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (start && !busy) begin
        if (cur.req == vrms_pkg::REQ_QUERY)
          expected_surf.insert(expected_surf.size(), march_predict(cur));
        else grid_occ[(cur.vz * DIM + cur.vy) * DIM + cur.vx] = cur.occ;
      end
      if (!start || !busy) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          start <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          gap_cnt <= $urandom_range(0, 5);
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur = pending_words.pop_front();
          in_req_type <= cur.req;
          in_voxel_x <= cur.vx;
          in_voxel_y <= cur.vy;
          in_voxel_z <= cur.vz;
          in_occupancy_value <= cur.occ;
          in_dir_x <= cur.dx;
          in_dir_y <= cur.dy;
          in_dir_z <= cur.dz;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_surf.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result radius=%0d hit=%0b",
                     out_surface_radius, out_surface_hit);
        end else begin
          surface_t e;
          e = expected_surf.pop_front();
          if (e.radius !== out_surface_radius || e.hit !== out_surface_hit) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: expected radius=%0d hit=%0b, got radius=%0d hit=%0b",
                       e.radius, e.hit, out_surface_radius, out_surface_hit);
          end
        end
      end
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready)) wdog <= 0;
      else if (wdog >= WDOG_MAX) begin
        $display("tb_voxel_ray_march_surface_top failed");
        $finish;
      end else wdog <= wdog + 1;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      vrms_pkg::REG_GRID_X: size_x = val[5:0];
      vrms_pkg::REG_GRID_Y: size_y = val[5:0];
      vrms_pkg::REG_GRID_Z: size_z = val[5:0];
      vrms_pkg::REG_THRESH: solid_thr = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || expected_surf.size() != 0 || start || busy);
    repeat (20) @(posedge clk);
  endtask

  function automatic voxel_req_t mk_write(int x, int y, int z, int v);
    voxel_req_t w;
    w.req = vrms_pkg::REQ_WRITE;
    w.vx = 5'(x); w.vy = 5'(y); w.vz = 5'(z); w.occ = 8'(v);
    w.dx = 16'($urandom); w.dy = 16'($urandom); w.dz = 16'($urandom);
    return w;
  endfunction

  function automatic voxel_req_t mk_query(int dx, int dy, int dz);
    voxel_req_t q;
    q.req = vrms_pkg::REQ_QUERY;
    q.vx = 5'($urandom); q.vy = 5'($urandom); q.vz = 5'($urandom);
    q.occ = 8'($urandom);
    q.dx = 16'(dx); q.dy = 16'(dy); q.dz = 16'(dz);
    return q;
  endfunction

  function automatic int rand_dir_comp(int mode);
    case (mode)
      0: return $urandom_range(0, 1) ? 16384 : -16384;
      1: return $signed(16'($urandom));
      2: return int'($urandom_range(0, 400)) - 200;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  // grid size register data; upper bits and out-of-range codes are exercised
  function automatic logic [7:0] size_code(int g);
    logic [7:0] c;
    c = 8'(g);
    if (g == 32 && $urandom_range(0, 2) == 0) c = 8'($urandom_range(33, 63));
    if (g == 1 && $urandom_range(0, 2) == 0) c = 8'd0;
    c[7:6] = 2'($urandom);
    return c;
  endfunction

  initial begin
    int total, gx, gy, gz, thr, rad2, d2, nq, m, ph;
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = vrms_pkg::REQ_WRITE;
    in_voxel_x = '0; in_voxel_y = '0; in_voxel_z = '0;
    in_occupancy_value = '0;
    in_dir_x = '0; in_dir_y = '0; in_dir_z = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    err_cnt = 0;
    wdog = 0;
    quiet = 1'b0;
    total = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single-voxel grid, center hit, miss, zero threshold, extremes
    reg_write(vrms_pkg::REG_GRID_X, 8'd0);
    reg_write(vrms_pkg::REG_GRID_Y, 8'd1);
    reg_write(vrms_pkg::REG_GRID_Z, 8'hC0);
    reg_write(vrms_pkg::REG_THRESH, 8'd1);
    add_word(mk_write(0, 0, 0, 255));
    add_word(mk_write(31, 31, 31, 170));
    add_word(mk_query(16384, 0, 0));
    add_word(mk_query(-32768, 32767, 0));
    add_word(mk_write(0, 0, 0, 0));
    add_word(mk_write(31, 0, 17, 85));
    add_word(mk_query(0, 0, 0));
    add_word(mk_query(-16384, -16384, 16384));
    wait_drained();
    reg_write(vrms_pkg::REG_THRESH, 8'd0);
    add_word(mk_write(0, 0, 0, 255));
    add_word(mk_query(0, 16384, 0));
    add_word(mk_query(32767, -32768, 32767));
    wait_drained();
    total = 11;

    ph = 0;
    while (total < N_ITEMS) begin
      gx = $urandom_range(1, 6);
      gy = $urandom_range(1, 6);
      gz = $urandom_range(1, 6);
      // one long axis in the early phases and now and then later
      if (ph < 3 || $urandom_range(0, 7) == 0) begin
        case (ph % 3)
          0: begin gx = 32; gy = $urandom_range(1, 3); gz = 1; end
          1: begin gy = 32; gz = $urandom_range(1, 3); gx = 1; end
          default: begin gz = 32; gx = $urandom_range(1, 3); gy = 1; end
        endcase
      end
      case ($urandom_range(0, 7))
        0: thr = 0;
        1: thr = 255;
        2: thr = 1;
        default: thr = $urandom_range(2, 254);
      endcase
      if (total > N_ITEMS * 85 / 100) quiet = 1'b1;
      reg_write(vrms_pkg::REG_GRID_X, size_code(gx));
      reg_write(vrms_pkg::REG_GRID_Y, size_code(gy));
      reg_write(vrms_pkg::REG_GRID_Z, size_code(gz));
      reg_write(vrms_pkg::REG_THRESH, thr[7:0]);

      // shell of solid voxels beyond a random radius, with some noise
      rad2 = $urandom_range(0, (gx-1)*(gx-1) + (gy-1)*(gy-1) + (gz-1)*(gz-1) + 2);
      for (int z = 0; z < gz; z++)
        for (int y = 0; y < gy; y++)
          for (int x = 0; x < gx; x++) begin
            d2 = (2*x-gx+1)*(2*x-gx+1) + (2*y-gy+1)*(2*y-gy+1) + (2*z-gz+1)*(2*z-gz+1);
            if ($urandom_range(0, 9) == 0) m = $urandom_range(0, 255);
            else if (d2 >= rad2) m = $urandom_range(thr, 255);
            else m = (thr == 0) ? 0 : $urandom_range(0, thr - 1);
            add_word(mk_write(x, y, z, m));
            total++;
          end

      nq = $urandom_range(15, 35);
      for (int i = 0; i < nq; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          // rewrite inside the grid or anywhere in the store
          if ($urandom_range(0, 1))
            add_word(mk_write($urandom_range(0, gx-1),
                $urandom_range(0, gy-1), $urandom_range(0, gz-1), $urandom));
          else
            add_word(mk_write($urandom, $urandom, $urandom, $urandom));
          total++;
        end
        m = $urandom_range(0, 9);
        m = (m < 1) ? 0 : (m < 2) ? 1 : (m < 3) ? 2 : 3;
        add_word(mk_query(rand_dir_comp(m), rand_dir_comp(m), rand_dir_comp(m)));
        total++;
      end
      wait_drained();
      ph++;
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (err_cnt == 0) $display("tb_voxel_ray_march_surface_top passed");
    else $display("tb_voxel_ray_march_surface_top failed");
    $finish;
  end

endmodule
